// ----- src/dual_node_failover_supervisor_macros.svh -----
// Assertion macros shared by the supervisor's checker.
`ifndef DUAL_NODE_FAILOVER_SUPERVISOR_MACROS_SVH
`define DUAL_NODE_FAILOVER_SUPERVISOR_MACROS_SVH

// Same-cycle implication, sampled on clk and idle while reset is held.
`define DNFS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dnfs: same-cycle check failed");

// Next-cycle implication, sampled on clk and idle while reset is held.
`define DNFS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dnfs: next-cycle check failed");

`endif

// ----- src/dnfs_pkg.sv -----
// Types and constants of the dual node failover supervisor.
`default_nettype none

package dnfs_pkg;

    localparam int ADDR_W = 3;

    typedef enum logic [2:0] {
        CMD_TICK      = 3'd0,
        CMD_HEARTBEAT = 3'd1,
        CMD_CHECK     = 3'd2,
        CMD_FAIL      = 3'd3,
        CMD_RECOVER   = 3'd4,
        CMD_WRITE     = 3'd5
    } cmd_t;

    typedef enum logic [1:0] {
        ROLE_ACTIVE   = 2'd0,
        ROLE_STANDBY  = 2'd1,
        ROLE_FAILED   = 2'd2,
        ROLE_ISOLATED = 2'd3
    } role_t;

    localparam logic [1:0] HEALTH_OK    = 2'd0;
    localparam logic [1:0] HEALTH_FAULT = 2'd3;

    localparam logic [7:0] MISS_MAX = 8'hFF;

    localparam logic [31:0] TIMEOUT_LIMIT_RST = 32'd3000;
    localparam logic [7:0]  MISS_LIMIT_RST    = 8'd3;

    typedef enum logic {
        REG_TIMEOUT_LIMIT = 1'b0,
        REG_MISS_LIMIT    = 1'b1
    } reg_idx_t;

    typedef struct packed {
        logic [31:0] timeout_limit;
        logic [7:0]  miss_limit;
    } cfg_t;

    typedef struct packed {
        logic [2:0]  command;
        logic        node;
        logic [31:0] elapsed_ms;
    } item_t;

    typedef struct packed {
        logic        ok;
        logic        timeout_found;
        logic        lead_node;
        logic [1:0]  role_node0;
        logic [1:0]  role_node1;
        logic [1:0]  health_node0;
        logic [1:0]  health_node1;
        logic [31:0] epoch_count;
        logic [31:0] failover_count;
        logic        cluster_healthy;
        logic        mirror_match;
    } result_t;

endpackage

`default_nettype wire

// ----- src/dual_node_failover_supervisor.sv -----
// Top level of the dual node active/standby failover supervisor.
// Commands arrive on the item channel (item_valid, item_stall, command, node,
// elapsed_ms) and each one yields exactly one status transaction on the
// result channel (result_valid, result_stall and the status fields).
// A command is captured in an input register and, once the result register
// can take it, is applied to the cluster state while its status lands in the
// result register at the same edge. One command is taken every cycle while
// result_stall is low, and the update between the registers is combinational.
// While result_stall is high the result register holds its transaction and
// the input register may still fill, so one more item is taken before
// item_stall rises. The timeout and miss limits are written over the APB
// port; the user must write them only while the block is idle, which the
// block itself does not enforce; pready is always high.
// Reset clears the valid flags of both pipeline registers, sets node 0 active
// and node 1 standby, both healthy, and loads the limits with 3000 and 3.
`default_nettype none

module dual_node_failover_supervisor (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [dnfs_pkg::ADDR_W-1:0] paddr,
    input  wire logic [31:0]                 pwdata,
    output logic      [31:0]                 prdata,
    output logic                             pready,
    input  wire logic                        item_valid,
    output logic                             item_stall,
    input  wire logic [2:0]                  command,
    input  wire logic                        node,
    input  wire logic [31:0]                 elapsed_ms,
    output logic                             result_valid,
    input  wire logic                        result_stall,
    output logic                             ok,
    output logic                             timeout_found,
    output logic                             lead_node,
    output logic      [1:0]                  role_node0,
    output logic      [1:0]                  role_node1,
    output logic      [1:0]                  health_node0,
    output logic      [1:0]                  health_node1,
    output logic      [31:0]                 epoch_count,
    output logic      [31:0]                 failover_count,
    output logic                             cluster_healthy,
    output logic                             mirror_match
);

    dnfs_pkg::cfg_t    cfg;
    dnfs_pkg::item_t   item_reg;
    dnfs_pkg::result_t eng_result;
    dnfs_pkg::result_t res_reg;
    logic              item_valid_reg;
    logic              item_valid_next;
    logic              res_valid_reg;
    logic              res_valid_next;
    logic              res_load;
    logic              fire;
    logic              accept;

    dnfs_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    dnfs_engine u_engine (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (fire),
        .item   (item_reg),
        .cfg    (cfg),
        .result (eng_result)
    );

    // The result register takes a new transaction when empty or being drained.
    assign res_load   = !res_valid_reg || !result_stall;
    assign fire       = item_valid_reg && res_load;
    assign item_stall = item_valid_reg && !res_load;
    assign accept     = item_valid && !item_stall;

    always_comb
    begin
        item_valid_next = item_valid_reg;
        if (accept)
        begin
            item_valid_next = 1'b1;
        end
        else if (fire)
        begin
            item_valid_next = 1'b0;
        end
        res_valid_next = res_load ? fire : res_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            item_valid_reg <= item_valid_next;
            res_valid_reg  <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg.command    <= command;
            item_reg.node       <= node;
            item_reg.elapsed_ms <= elapsed_ms;
        end
        if (fire)
        begin
            res_reg <= eng_result;
        end
    end

    assign result_valid    = res_valid_reg;
    assign ok              = res_reg.ok;
    assign timeout_found   = res_reg.timeout_found;
    assign lead_node       = res_reg.lead_node;
    assign role_node0      = res_reg.role_node0;
    assign role_node1      = res_reg.role_node1;
    assign health_node0    = res_reg.health_node0;
    assign health_node1    = res_reg.health_node1;
    assign epoch_count     = res_reg.epoch_count;
    assign failover_count  = res_reg.failover_count;
    assign cluster_healthy = res_reg.cluster_healthy;
    assign mirror_match    = res_reg.mirror_match;

endmodule

`default_nettype wire

// ----- src/dnfs_cfg.sv -----
// APB register bank holding the timeout and miss limits.
`default_nettype none

module dnfs_cfg (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [dnfs_pkg::ADDR_W-1:0] paddr,
    input  wire logic [31:0]                 pwdata,
    output logic      [31:0]                 prdata,
    output logic                             pready,
    output dnfs_pkg::cfg_t                   cfg
);

    dnfs_pkg::cfg_t   cfg_reg;
    dnfs_pkg::cfg_t   cfg_next;
    dnfs_pkg::reg_idx_t reg_idx;
    logic             wr_en;

    assign pready  = 1'b1;
    assign reg_idx = dnfs_pkg::reg_idx_t'(paddr[2]);
    assign wr_en   = psel && penable && pwrite && pready;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (reg_idx)
                dnfs_pkg::REG_TIMEOUT_LIMIT: cfg_next.timeout_limit = pwdata;
                dnfs_pkg::REG_MISS_LIMIT:    cfg_next.miss_limit    = pwdata[7:0];
                default:                     cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            dnfs_pkg::REG_TIMEOUT_LIMIT: prdata = cfg_reg.timeout_limit;
            dnfs_pkg::REG_MISS_LIMIT:    prdata = {24'd0, cfg_reg.miss_limit};
            default:                     prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.timeout_limit <= dnfs_pkg::TIMEOUT_LIMIT_RST;
            cfg_reg.miss_limit    <= dnfs_pkg::MISS_LIMIT_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// ----- src/dnfs_engine.sv -----
// Cluster state registers and the combinational command update.
`default_nettype none

module dnfs_engine (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            fire,
    input  wire dnfs_pkg::item_t item,
    input  wire dnfs_pkg::cfg_t  cfg,
    output dnfs_pkg::result_t    result
);

    dnfs_pkg::role_t role_reg   [2];
    dnfs_pkg::role_t role_next  [2];
    logic [1:0]      health_reg [2];
    logic [1:0]      health_next[2];
    logic [31:0]     heard_reg  [2];
    logic [31:0]     heard_next [2];
    logic [7:0]      missed_reg [2];
    logic [7:0]      missed_next[2];
    logic [31:0]     ver_reg    [2];
    logic [31:0]     ver_next   [2];
    logic [31:0]     now_reg;
    logic [31:0]     now_next;
    logic            active_reg;
    logic            active_next;
    logic [31:0]     epoch_reg;
    logic [31:0]     epoch_next;
    logic [31:0]     failovers_reg;
    logic [31:0]     failovers_next;

    logic [1:0]      unusable;
    logic            peer;
    logic [31:0]     since_heard;
    logic [7:0]      missed_inc;
    logic [31:0]     ver_inc;
    logic            ok;
    logic            tmo;

    always_comb
    begin
        for (int i = 0; i < 2; i++)
        begin
            unusable[i] = (health_reg[i] == dnfs_pkg::HEALTH_FAULT) ||
                          (role_reg[i] == dnfs_pkg::ROLE_FAILED);
        end
    end

    assign peer        = ~item.node;
    assign since_heard = now_reg - heard_reg[item.node];
    assign missed_inc  = (missed_reg[item.node] == dnfs_pkg::MISS_MAX) ?
                         missed_reg[item.node] : missed_reg[item.node] + 8'd1;
    assign ver_inc     = ver_reg[active_reg] + 32'd1;

    always_comb
    begin
        logic sb;
        role_next      = role_reg;
        health_next    = health_reg;
        heard_next     = heard_reg;
        missed_next    = missed_reg;
        ver_next       = ver_reg;
        now_next       = now_reg;
        active_next    = active_reg;
        epoch_next     = epoch_reg;
        failovers_next = failovers_reg;
        ok             = 1'b0;
        tmo            = 1'b0;
        sb             = 1'b0;
        unique case (dnfs_pkg::cmd_t'(item.command))
            dnfs_pkg::CMD_TICK:
            begin
                now_next = now_reg + item.elapsed_ms;
                ok       = 1'b1;
            end
            dnfs_pkg::CMD_HEARTBEAT:
            begin
                // The sender's heartbeat refreshes what its peer last heard.
                if (!unusable[item.node] && !unusable[peer])
                begin
                    heard_next[peer]  = now_reg;
                    missed_next[peer] = 8'd0;
                    ok                = 1'b1;
                end
            end
            dnfs_pkg::CMD_CHECK:
            begin
                if (!unusable[peer] && (since_heard > cfg.timeout_limit))
                begin
                    missed_next[item.node] = missed_inc;
                    tmo = (missed_inc >= cfg.miss_limit);
                end
                ok = tmo;
            end
            dnfs_pkg::CMD_FAIL:
            begin
                health_next[item.node] = dnfs_pkg::HEALTH_FAULT;
                role_next[item.node]   = dnfs_pkg::ROLE_FAILED;
                if (item.node != active_reg)
                begin
                    ok = 1'b1;
                end
                else if (!unusable[peer])
                begin
                    role_next[peer] = dnfs_pkg::ROLE_ACTIVE;
                    active_next     = peer;
                    epoch_next      = epoch_reg + 32'd1;
                    failovers_next  = failovers_reg + 32'd1;
                    ok              = 1'b1;
                end
            end
            dnfs_pkg::CMD_RECOVER:
            begin
                health_next[item.node] = dnfs_pkg::HEALTH_OK;
                missed_next[item.node] = 8'd0;
                if (active_reg != item.node)
                begin
                    role_next[item.node] = dnfs_pkg::ROLE_STANDBY;
                end
                else if (role_reg[peer] != dnfs_pkg::ROLE_ACTIVE)
                begin
                    role_next[item.node] = dnfs_pkg::ROLE_ACTIVE;
                end
                else
                begin
                    role_next[item.node] = dnfs_pkg::ROLE_STANDBY;
                    active_next          = peer;
                end
                // The mirror sync looks at the roles as they stand after re-roling.
                sb = ~active_next;
                if ((health_next[sb] != dnfs_pkg::HEALTH_FAULT) &&
                    (role_next[sb] != dnfs_pkg::ROLE_FAILED))
                begin
                    ver_next[sb] = ver_reg[active_next];
                end
                ok = 1'b1;
            end
            dnfs_pkg::CMD_WRITE:
            begin
                sb                   = ~active_reg;
                ver_next[active_reg] = ver_inc;
                if (!unusable[sb])
                begin
                    ver_next[sb] = ver_inc;
                    ok           = 1'b1;
                end
            end
            default:
            begin
                ok = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        result.ok              = ok;
        result.timeout_found   = tmo;
        result.lead_node       = active_next;
        result.role_node0      = role_next[0];
        result.role_node1      = role_next[1];
        result.health_node0    = health_next[0];
        result.health_node1    = health_next[1];
        result.epoch_count     = epoch_next;
        result.failover_count  = failovers_next;
        result.cluster_healthy =
            ((role_next[0] == dnfs_pkg::ROLE_ACTIVE) &&
             (health_next[0] == dnfs_pkg::HEALTH_OK)) ||
            ((role_next[1] == dnfs_pkg::ROLE_ACTIVE) &&
             (health_next[1] == dnfs_pkg::HEALTH_OK));
        result.mirror_match    = (health_next[0] != dnfs_pkg::HEALTH_FAULT) &&
                                 (health_next[1] != dnfs_pkg::HEALTH_FAULT) &&
                                 (ver_next[0] == ver_next[1]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            role_reg[0]   <= dnfs_pkg::ROLE_ACTIVE;
            role_reg[1]   <= dnfs_pkg::ROLE_STANDBY;
            for (int i = 0; i < 2; i++)
            begin
                health_reg[i] <= dnfs_pkg::HEALTH_OK;
                heard_reg[i]  <= 32'd0;
                missed_reg[i] <= 8'd0;
                ver_reg[i]    <= 32'd0;
            end
            now_reg       <= 32'd0;
            active_reg    <= 1'b0;
            epoch_reg     <= 32'd0;
            failovers_reg <= 32'd0;
        end
        else if (fire)
        begin
            role_reg      <= role_next;
            health_reg    <= health_next;
            heard_reg     <= heard_next;
            missed_reg    <= missed_next;
            ver_reg       <= ver_next;
            now_reg       <= now_next;
            active_reg    <= active_next;
            epoch_reg     <= epoch_next;
            failovers_reg <= failovers_next;
        end
    end

endmodule

`default_nettype wire

// ----- src/dnfs_checker.sv -----
// Port-level checker for the failover supervisor and its bind.
`default_nettype none

`include "dual_node_failover_supervisor_macros.svh"

module dnfs_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        result_valid,
    input wire logic        result_stall,
    input wire logic        ok,
    input wire logic        timeout_found,
    input wire logic [1:0]  health_node0,
    input wire logic [1:0]  health_node1,
    input wire logic [31:0] epoch_count,
    input wire logic [31:0] failover_count,
    input wire logic        mirror_match
);

    // A stalled transaction stays on the result port with its epoch count and ok flag unchanged.
    `DNFS_ASSERT_NEXT(a_res_hold, result_valid && result_stall, result_valid && $stable(epoch_count) && $stable(ok))

    // A found timeout is always reported as a successful check.
    `DNFS_ASSERT_NOW(a_tmo_ok, result_valid && timeout_found, ok)

    // Every failover steps the epoch and the failover count together.
    `DNFS_ASSERT_NOW(a_epoch_fo, result_valid, epoch_count == failover_count)

    // The mirror is never reported in step while a node is dead.
    `DNFS_ASSERT_NOW(a_mirror_live, result_valid && mirror_match, (health_node0 != dnfs_pkg::HEALTH_FAULT) && (health_node1 != dnfs_pkg::HEALTH_FAULT))

endmodule

bind dual_node_failover_supervisor dnfs_checker u_dnfs_checker (.*);

`default_nettype wire

// ----- verif/dual_node_failover_supervisor_test.sv -----
// Self-checking testbench for the dual node failover supervisor: queued commands, cluster predictor.
`timescale 1ns / 100ps

module dual_node_failover_supervisor_test;

    localparam int CYCLE_LIMIT = 200000;
    localparam int PROF_MIXED = 0;
    localparam int PROF_SATURATE = 1;
    localparam logic [2:0] CMD_SPARE6 = 3'd6;
    localparam logic [2:0] CMD_SPARE7 = 3'd7;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                        psel = 1'b0;
    logic                        penable = 1'b0;
    logic                        pwrite = 1'b0;
    logic [dnfs_pkg::ADDR_W-1:0] paddr = '0;
    logic [31:0]                 pwdata = '0;
    logic [31:0]                 prdata;
    logic                        pready;
    logic                        item_valid = 1'b0;
    logic                        item_stall;
    logic [2:0]                  command = '0;
    logic                        node = 1'b0;
    logic [31:0]                 elapsed_ms = '0;
    logic                        result_valid;
    logic                        result_stall = 1'b0;
    logic                        ok;
    logic                        timeout_found;
    logic                        lead_node;
    logic [1:0]                  role_node0;
    logic [1:0]                  role_node1;
    logic [1:0]                  health_node0;
    logic [1:0]                  health_node1;
    logic [31:0]                 epoch_count;
    logic [31:0]                 failover_count;
    logic                        cluster_healthy;
    logic                        mirror_match;

    // Commands waiting to be sent and cluster status still to come back.
    dnfs_pkg::item_t   pending_cmds[$];
    dnfs_pkg::result_t expected_status[$];
    dnfs_pkg::item_t   drv_item;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int mismatches = 0;
    int cycle_count = 0;

    // Predicted cluster state and limits.
    dnfs_pkg::role_t role_q [2] = '{dnfs_pkg::ROLE_ACTIVE, dnfs_pkg::ROLE_STANDBY};
    logic [1:0]  health_q [2] = '{dnfs_pkg::HEALTH_OK, dnfs_pkg::HEALTH_OK};
    logic [31:0] heard_at [2] = '{32'd0, 32'd0};
    logic [7:0]  missed [2] = '{8'd0, 8'd0};
    logic [31:0] version [2] = '{32'd0, 32'd0};
    logic [31:0] clock_ms = '0;
    logic        lead_sel = 1'b0;
    logic [31:0] epoch_n = '0;
    logic [31:0] failovers_n = '0;
    logic [31:0] lim_timeout = dnfs_pkg::TIMEOUT_LIMIT_RST;
    logic [7:0]  lim_miss = dnfs_pkg::MISS_LIMIT_RST;

    dual_node_failover_supervisor dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .item_valid     (item_valid),
        .item_stall     (item_stall),
        .command        (command),
        .node           (node),
        .elapsed_ms     (elapsed_ms),
        .result_valid   (result_valid),
        .result_stall   (result_stall),
        .ok             (ok),
        .timeout_found  (timeout_found),
        .lead_node      (lead_node),
        .role_node0     (role_node0),
        .role_node1     (role_node1),
        .health_node0   (health_node0),
        .health_node1   (health_node1),
        .epoch_count    (epoch_count),
        .failover_count (failover_count),
        .cluster_healthy(cluster_healthy),
        .mirror_match   (mirror_match)
    );

    always #5 clk = ~clk;

    function automatic bit node_down(input logic n);
        return health_q[n] == dnfs_pkg::HEALTH_FAULT || role_q[n] == dnfs_pkg::ROLE_FAILED;
    endfunction

    function automatic bit sync_standby();
        logic a;
        logic s;
        a = lead_sel;
        s = ~a;
        if (node_down(s))
            return 1'b0;
        version[s] = version[a];
        return 1'b1;
    endfunction

    // Applies one command to the predicted cluster and returns the status it reports.
    task automatic supervise(input dnfs_pkg::item_t it, output dnfs_pkg::result_t r);
        logic        n;
        logic        p;
        logic        ok_b;
        logic        tmo_b;
        logic [31:0] gap;
        n = it.node;
        p = ~n;
        ok_b = 1'b0;
        tmo_b = 1'b0;
        case (it.command)
            dnfs_pkg::CMD_TICK:
            begin
                clock_ms = clock_ms + it.elapsed_ms;
                ok_b = 1'b1;
            end
            dnfs_pkg::CMD_HEARTBEAT:
            begin
                if (!node_down(n) && !node_down(p))
                begin
                    heard_at[p] = clock_ms;
                    missed[p] = 8'd0;
                    ok_b = 1'b1;
                end
            end
            dnfs_pkg::CMD_CHECK:
            begin
                gap = clock_ms - heard_at[n];
                if (!node_down(p) && gap > lim_timeout)
                begin
                    if (missed[n] != dnfs_pkg::MISS_MAX)
                        missed[n] = missed[n] + 8'd1;
                    tmo_b = (missed[n] >= lim_miss);
                end
                ok_b = tmo_b;
            end
            dnfs_pkg::CMD_FAIL:
            begin
                health_q[n] = dnfs_pkg::HEALTH_FAULT;
                role_q[n] = dnfs_pkg::ROLE_FAILED;
                if (n != lead_sel)
                    ok_b = 1'b1;
                else if (!node_down(p))
                begin
                    role_q[p] = dnfs_pkg::ROLE_ACTIVE;
                    lead_sel = p;
                    epoch_n = epoch_n + 32'd1;
                    failovers_n = failovers_n + 32'd1;
                    ok_b = 1'b1;
                end
            end
            dnfs_pkg::CMD_RECOVER:
            begin
                health_q[n] = dnfs_pkg::HEALTH_OK;
                missed[n] = 8'd0;
                if (lead_sel != n)
                    role_q[n] = dnfs_pkg::ROLE_STANDBY;
                else if (role_q[p] != dnfs_pkg::ROLE_ACTIVE)
                    role_q[n] = dnfs_pkg::ROLE_ACTIVE;
                else
                begin
                    role_q[n] = dnfs_pkg::ROLE_STANDBY;
                    lead_sel = p;
                end
                void'(sync_standby());
                ok_b = 1'b1;
            end
            dnfs_pkg::CMD_WRITE:
            begin
                version[lead_sel] = version[lead_sel] + 32'd1;
                ok_b = sync_standby();
            end
            default:
            begin
            end
        endcase
        r.ok = ok_b;
        r.timeout_found = tmo_b;
        r.lead_node = lead_sel;
        r.role_node0 = role_q[0];
        r.role_node1 = role_q[1];
        r.health_node0 = health_q[0];
        r.health_node1 = health_q[1];
        r.epoch_count = epoch_n;
        r.failover_count = failovers_n;
        r.cluster_healthy =
            (role_q[0] == dnfs_pkg::ROLE_ACTIVE && health_q[0] == dnfs_pkg::HEALTH_OK) ||
            (role_q[1] == dnfs_pkg::ROLE_ACTIVE && health_q[1] == dnfs_pkg::HEALTH_OK);
        r.mirror_match = health_q[0] != dnfs_pkg::HEALTH_FAULT &&
                         health_q[1] != dnfs_pkg::HEALTH_FAULT &&
                         version[0] == version[1];
    endtask

    task automatic check_field(input string label, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0h, got %0h", label, want, got);
            mismatches++;
        end
    endtask

    task automatic push_cmd(input logic [2:0] cmd, input logic n, input logic [31:0] ms);
        dnfs_pkg::item_t it;
        it.command = cmd;
        it.node = n;
        it.elapsed_ms = ms;
        pending_cmds.push_back(it);
    endtask

    function automatic logic [31:0] tick_amount();
        int sel;
        sel = $urandom_range(9);
        if (sel < 6)
            return $urandom_range(64);
        else if (sel < 9)
            return $urandom_range(4000);
        return $urandom;
    endfunction

    task automatic fill_random(input int count, input int profile);
        int w;
        logic n;
        for (int k = 0; k < count; k++)
        begin
            w = $urandom_range(99);
            n = 1'($urandom_range(1));
            if (profile == PROF_SATURATE)
            begin
                // Long runs of checks on node 0 with no heartbeat drive its count to the ceiling.
                if (w < 80)
                    push_cmd(dnfs_pkg::CMD_CHECK, ($urandom_range(9) == 0), $urandom);
                else if (w < 95)
                    push_cmd(dnfs_pkg::CMD_TICK, n, $urandom_range(1, 50));
                else
                    push_cmd(dnfs_pkg::CMD_WRITE, n, $urandom);
            end
            else if (w < 25)
                push_cmd(dnfs_pkg::CMD_TICK, n, tick_amount());
            else if (w < 45)
                push_cmd(dnfs_pkg::CMD_HEARTBEAT, n, $urandom);
            else if (w < 70)
                push_cmd(dnfs_pkg::CMD_CHECK, n, $urandom);
            else if (w < 78)
                push_cmd(dnfs_pkg::CMD_FAIL, n, $urandom);
            else if (w < 90)
                push_cmd(dnfs_pkg::CMD_RECOVER, n, $urandom);
            else if (w < 98)
                push_cmd(dnfs_pkg::CMD_WRITE, n, $urandom);
            else
                push_cmd(($urandom_range(1) == 0) ? CMD_SPARE6 : CMD_SPARE7, n, $urandom);
        end
    endtask

    // Returns once every command has been sent and its status has come back.
    task automatic wait_idle();
        do
            @(posedge clk);
        while (pending_cmds.size() != 0 || item_valid || expected_status.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input dnfs_pkg::reg_idx_t idx, input logic [31:0] value);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            dnfs_pkg::REG_TIMEOUT_LIMIT: lim_timeout = value;
            dnfs_pkg::REG_MISS_LIMIT:    lim_miss = value[7:0];
            default:                     lim_miss = lim_miss;
        endcase
    endtask

    task automatic apply_limits(input logic [31:0] tmo, input logic [7:0] miss);
        write_reg(dnfs_pkg::REG_TIMEOUT_LIMIT, tmo);
        write_reg(dnfs_pkg::REG_MISS_LIMIT, {24'd0, miss});
    endtask

    task automatic run_phase(input logic [31:0] tmo, input logic [7:0] miss, input int count,
                             input int profile, input int idle_pct, input int stall_pct);
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        apply_limits(tmo, miss);
        if (profile == PROF_SATURATE)
        begin
            push_cmd(dnfs_pkg::CMD_RECOVER, 1'b1, 32'd0);
            push_cmd(dnfs_pkg::CMD_RECOVER, 1'b0, 32'd0);
        end
        fill_random(count, profile);
        wait_idle();
    endtask

    // Sender: offers the next queued command once the current transaction has gone.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (!item_valid || !item_stall)
            begin
                if (pending_cmds.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    drv_item = pending_cmds.pop_front();
                    item_valid <= 1'b1;
                    command <= drv_item.command;
                    node <= drv_item.node;
                    elapsed_ms <= drv_item.elapsed_ms;
                end
                else
                    item_valid <= 1'b0;
            end
        end
    end

    // Every accepted command is run through the predictor at its acceptance edge.
    always @(posedge clk)
    begin : predict_block
        dnfs_pkg::item_t   seen;
        dnfs_pkg::result_t want;
        if (rst_n && item_valid && !item_stall)
        begin
            seen.command = command;
            seen.node = node;
            seen.elapsed_ms = elapsed_ms;
            supervise(seen, want);
            expected_status.push_back(want);
        end
    end

    always @(posedge clk)
    begin : status_check
        dnfs_pkg::result_t want;
        if (rst_n)
        begin
            if (result_valid && !result_stall)
            begin
                if (expected_status.size() == 0)
                begin
                    $error("status transaction with no command outstanding");
                    mismatches++;
                end
                else
                begin
                    want = expected_status.pop_front();
                    check_field("ok", want.ok, ok);
                    check_field("timeout_found", want.timeout_found, timeout_found);
                    check_field("lead_node", want.lead_node, lead_node);
                    check_field("role_node0", want.role_node0, role_node0);
                    check_field("role_node1", want.role_node1, role_node1);
                    check_field("health_node0", want.health_node0, health_node0);
                    check_field("health_node1", want.health_node1, health_node1);
                    check_field("epoch_count", want.epoch_count, epoch_count);
                    check_field("failover_count", want.failover_count, failover_count);
                    check_field("cluster_healthy", want.cluster_healthy, cluster_healthy);
                    check_field("mirror_match", want.mirror_match, mirror_match);
                end
            end
            result_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("dual_node_failover_supervisor_test failed");
            $finish;
        end
    end

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        wait_idle();

        send_idle_pct = 30;
        recv_stall_pct = 79;
        apply_limits(32'd100, 8'd2);

        // Unused codes, time wrap and the miss count reaching its limit.
        push_cmd(CMD_SPARE6, 1'b0, 32'd0);
        push_cmd(CMD_SPARE7, 1'b1, 32'hFFFF_FFFF);
        push_cmd(dnfs_pkg::CMD_TICK, 1'b0, 32'd0);
        push_cmd(dnfs_pkg::CMD_TICK, 1'b1, 32'hFFFF_FFFF);
        push_cmd(dnfs_pkg::CMD_TICK, 1'b0, 32'd1);
        push_cmd(dnfs_pkg::CMD_CHECK, 1'b0, 32'd0);
        push_cmd(dnfs_pkg::CMD_TICK, 1'b0, 32'd101);
        push_cmd(dnfs_pkg::CMD_CHECK, 1'b0, 32'd0);
        push_cmd(dnfs_pkg::CMD_CHECK, 1'b0, 32'd0);
        push_cmd(dnfs_pkg::CMD_HEARTBEAT, 1'b1, 32'd0);
        push_cmd(dnfs_pkg::CMD_HEARTBEAT, 1'b0, 32'd0);
        push_cmd(dnfs_pkg::CMD_WRITE, 1'b0, 32'd0);
        // Standby lost: heartbeats and checks refused, writes no longer mirrored.
        push_cmd(dnfs_pkg::CMD_FAIL, 1'b1, 32'd0);
        push_cmd(dnfs_pkg::CMD_HEARTBEAT, 1'b0, 32'd0);
        push_cmd(dnfs_pkg::CMD_HEARTBEAT, 1'b1, 32'd0);
        push_cmd(dnfs_pkg::CMD_CHECK, 1'b0, 32'd0);
        push_cmd(dnfs_pkg::CMD_WRITE, 1'b1, 32'd0);
        // Active lost with no usable standby, then recovery and failovers both ways.
        push_cmd(dnfs_pkg::CMD_FAIL, 1'b0, 32'd0);
        push_cmd(dnfs_pkg::CMD_RECOVER, 1'b1, 32'd0);
        push_cmd(dnfs_pkg::CMD_RECOVER, 1'b0, 32'd0);
        push_cmd(dnfs_pkg::CMD_FAIL, 1'b0, 32'd0);
        push_cmd(dnfs_pkg::CMD_RECOVER, 1'b0, 32'd0);
        push_cmd(dnfs_pkg::CMD_FAIL, 1'b1, 32'd0);
        push_cmd(dnfs_pkg::CMD_RECOVER, 1'b1, 32'd0);
        push_cmd(dnfs_pkg::CMD_WRITE, 1'b0, 32'd0);
        fill_random(200, PROF_MIXED);
        wait_idle();

        run_phase(32'd0, 8'd255, 400, PROF_SATURATE, 79, 30);
        run_phase(32'hFFFF_FFFF, 8'd1, 150, PROF_MIXED, 79, 30);
        // A miss limit of zero makes every counted miss a timeout.
        run_phase(32'd0, 8'd0, 100, PROF_MIXED, 0, 0);
        run_phase(dnfs_pkg::TIMEOUT_LIMIT_RST, dnfs_pkg::MISS_LIMIT_RST, 150, PROF_MIXED, 0, 0);
        run_phase(32'($urandom_range(200)), 8'($urandom_range(1, 255)), 100, PROF_MIXED, 0, 0);

        repeat (10) @(posedge clk);
        if (mismatches == 0 && expected_status.size() == 0)
            $display("dual_node_failover_supervisor_test passed");
        else
            $display("dual_node_failover_supervisor_test failed");
        $finish;
    end

endmodule
